// ===== rtl/qra_pkg.sv =====
// Shared types and constants for the requantizing u8 adder.
// Coefficient selector codes, item kinds, coefficient set and datapath widths.
// No dependencies.
package qra_pkg;

  localparam int CHANNEL_SLOTS_DEF = 1024;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int BYTE_W  = 8;
  localparam int CH_W    = 10;
  localparam int SEL_W   = 3;
  localparam int COEF_W  = 32;
  localparam int NUM_COEF = 6;

  // datapath widths: product, sum, split multiply, total
  localparam int PROD_W = BYTE_W + 1 + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int LO_W   = 22;
  localparam int MLO_W  = LO_W + 1 + COEF_W;
  localparam int MHI_W  = SUM_W - LO_W + COEF_W;
  localparam int TOT_W  = SUM_W + COEF_W + 1;

  localparam logic [BYTE_W-1:0] UPPER_RST = 8'd255;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef enum logic [SEL_W-1:0] {
    SEL_A_SCALE = 3'd0,
    SEL_A_SHIFT = 3'd1,
    SEL_B_SCALE = 3'd2,
    SEL_B_SHIFT = 3'd3,
    SEL_C_SCALE = 3'd4,
    SEL_C_SHIFT = 3'd5
  } coef_sel_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t a_scale;
    coef_t a_shift;
    coef_t b_scale;
    coef_t b_shift;
    coef_t c_scale;
    coef_t c_shift;
  } coef_set_t;

endpackage

// ===== rtl/qra_coef_mem.sv =====
// Per-channel coefficient store: six single-port-write, registered-read memories.
// Depends on qra_pkg.
module qra_coef_mem import qra_pkg::*; #(
  parameter int SLOTS  = CHANNEL_SLOTS_DEF,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SEL_W-1:0]  wr_sel,
  input  logic [ADDR_W-1:0] wr_addr,
  input  coef_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output coef_set_t         rd_data
);

  logic [NUM_COEF-1:0] we;
  coef_t               rd_q [NUM_COEF];

  always_comb begin
    we = '0;
    case (coef_sel_t'(wr_sel))
      SEL_A_SCALE: we[0] = wr_en;
      SEL_A_SHIFT: we[1] = wr_en;
      SEL_B_SCALE: we[2] = wr_en;
      SEL_B_SHIFT: we[3] = wr_en;
      SEL_C_SCALE: we[4] = wr_en;
      SEL_C_SHIFT: we[5] = wr_en;
      default:     we = '0;
    endcase
  end

  for (genvar g = 0; g < NUM_COEF; g++) begin : g_tbl
    coef_t mem [SLOTS];

    always_ff @(posedge clk) begin
      if (we[g]) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_q[g] <= mem[rd_addr];
      end
    end
  end

  assign rd_data.a_scale = rd_q[0];
  assign rd_data.a_shift = rd_q[1];
  assign rd_data.b_scale = rd_q[2];
  assign rd_data.b_shift = rd_q[3];
  assign rd_data.c_scale = rd_q[4];
  assign rd_data.c_shift = rd_q[5];

endmodule

// ===== rtl/quantized_u8_requant_add_core.sv =====
// Top level of the per-channel requantizing u8 adder: ports, six-stage pipeline.
// Depends on qra_pkg and qra_coef_mem.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | kind, channel, coef_select, coef_value, a, b
//  out     | out_valid / out_ready| out_value
//  cfg     | cfg_wr_en            | cfg_wr_data (upper_limit)
//
// One transaction per cycle in while in_ready is high; a compute passes through these stages:
// table read, two byte multiplies, sum, split 43x32 multiply, total, round/clamp.
// Each stage moves when its successor is empty or moving, so bubbles collapse
// and a waiting result does not block input until the pipe is full.
// Loads write the tables at acceptance and produce no output.
// rst_n is synchronous; the coefficient tables are not cleared.
module quantized_u8_requant_add_core import qra_pkg::*; #(
  parameter int CHANNEL_SLOTS = CHANNEL_SLOTS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [CH_W-1:0]          in_channel,
  input  logic [SEL_W-1:0]         in_coef_select,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic [BYTE_W-1:0]        in_a_value,
  input  logic [BYTE_W-1:0]        in_b_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [BYTE_W-1:0]        out_value,
  input  logic                     cfg_wr_en,
  input  logic [BYTE_W-1:0]        cfg_wr_data
);

  localparam int ADDR_W = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
  // one spare bit so the slot count itself is representable in the range check
  localparam int CHX_W  = ((ADDR_W > CH_W) ? ADDR_W : CH_W) + 1;
  localparam int D_W    = 2 * FRAC_BITS;
  localparam int Q_W    = TOT_W - D_W;
  localparam int NSTG   = 5;

  // config
  logic [BYTE_W-1:0] upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RST;
    end else if (cfg_wr_en) begin
      upper_r <= cfg_wr_data;
    end
  end

  // stage control
  logic [NSTG:1] vld_r;
  logic [NSTG:1] rdy;
  logic          out_valid_r;
  logic          out_rdy;
  logic          in_acc;

  assign out_rdy = !out_valid_r || out_ready;
  assign rdy[NSTG] = !vld_r[NSTG] || out_rdy;
  for (genvar k = 1; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  assign in_ready = rdy[1];
  assign in_acc   = in_valid && rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid && (in_kind == KIND_COMPUTE);
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (out_rdy) begin
        out_valid_r <= vld_r[NSTG];
      end
    end
  end

  // stage 0: table access
  logic [CHX_W-1:0]  ch_ext;
  logic [ADDR_W-1:0] addr;
  logic              oor;
  coef_set_t         coef;

  assign ch_ext = CHX_W'(in_channel);
  assign addr   = ch_ext[ADDR_W-1:0];
  assign oor    = ch_ext >= CHX_W'(CHANNEL_SLOTS);

  qra_coef_mem #(
    .SLOTS  (CHANNEL_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (in_acc && (in_kind == KIND_LOAD) && !oor),
    .wr_sel  (in_coef_select),
    .wr_addr (addr),
    .wr_data (in_coef_value),
    .rd_en   (in_acc && (in_kind == KIND_COMPUTE)),
    .rd_addr (addr),
    .rd_data (coef)
  );

  // stage 1 payload
  logic [BYTE_W-1:0] a1_r, b1_r;
  logic              oor1_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a1_r   <= in_a_value;
      b1_r   <= in_b_value;
      oor1_r <= oor;
    end
  end

  // stage 2: byte products
  logic signed [PROD_W-1:0] pa2_r, pb2_r, pa2_nxt, pb2_nxt;
  coef_t                    ash2_r, bsh2_r, cs2_r, csh2_r;
  logic                     oor2_r;

  assign pa2_nxt = $signed({1'b0, a1_r}) * coef.a_scale;
  assign pb2_nxt = $signed({1'b0, b1_r}) * coef.b_scale;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pa2_r  <= pa2_nxt;
      pb2_r  <= pb2_nxt;
      ash2_r <= coef.a_shift;
      bsh2_r <= coef.b_shift;
      cs2_r  <= coef.c_scale;
      csh2_r <= coef.c_shift;
      oor2_r <= oor1_r;
    end
  end

  // stage 3: sum
  logic signed [SUM_W-1:0] s3_r, s3_nxt;
  coef_t                   cs3_r, csh3_r;
  logic                    oor3_r;

  assign s3_nxt = SUM_W'(pa2_r) + SUM_W'(ash2_r) + SUM_W'(pb2_r) + SUM_W'(bsh2_r);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_r   <= s3_nxt;
      cs3_r  <= cs2_r;
      csh3_r <= csh2_r;
      oor3_r <= oor2_r;
    end
  end

  // stage 4: split multiply by c scale
  logic signed [MLO_W-1:0] mlo4_r, mlo4_nxt;
  logic signed [MHI_W-1:0] mhi4_r, mhi4_nxt;
  coef_t                   csh4_r;
  logic                    oor4_r;

  assign mlo4_nxt = $signed({1'b0, s3_r[LO_W-1:0]}) * cs3_r;
  assign mhi4_nxt = $signed(s3_r[SUM_W-1:LO_W]) * cs3_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      mlo4_r <= mlo4_nxt;
      mhi4_r <= mhi4_nxt;
      csh4_r <= csh3_r;
      oor4_r <= oor3_r;
    end
  end

  // stage 5: total with 2*FRAC_BITS fraction bits
  logic signed [TOT_W-1:0] tot5_r, tot5_nxt;
  logic                    oor5_r;

  assign tot5_nxt = (TOT_W'(mhi4_r) <<< LO_W) + TOT_W'(mlo4_r)
                  + (TOT_W'(csh4_r) <<< FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      tot5_r <= tot5_nxt;
      oor5_r <= oor4_r;
    end
  end

  // output: round half to even, clamp
  logic [Q_W-1:0]    q;
  logic [D_W-1:0]    rem;
  logic [D_W-1:0]    half;
  logic              up;
  logic [BYTE_W-1:0] res_nxt;
  logic [BYTE_W-1:0] out_value_r;

  assign q    = tot5_r[TOT_W-1:D_W];
  assign rem  = tot5_r[D_W-1:0];
  assign half = D_W'(1) << (D_W - 1);
  assign up   = (rem > half) || ((rem == half) && q[0]);

  always_comb begin
    if (oor5_r || tot5_r[TOT_W-1]) begin
      res_nxt = '0;
    end else if (q >= Q_W'(upper_r)) begin
      res_nxt = upper_r;
    end else begin
      res_nxt = q[BYTE_W-1:0] + BYTE_W'(up);
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_value_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

// ===== rtl/qra_checker.sv =====
// Port-level checks for the requantizing u8 adder, bound to the top level.
// Depends on qra_pkg and quantized_u8_requant_add_core.
module qra_checker import qra_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_value,
  input logic              cfg_wr_en,
  input logic [BYTE_W-1:0] cfg_wr_data
);

  logic [BYTE_W-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= UPPER_RST;
    end else if (cfg_wr_en) begin
      lim_r <= cfg_wr_data;
    end
  end

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value <= lim_r))
    else $error("result above upper limit");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled transaction changed");

endmodule

bind quantized_u8_requant_add_core qra_checker u_qra_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_value   (out_value),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);

// ===== bench/tb_quantized_u8_requant_add_core.sv =====
`timescale 1ns / 100ps
// Testbench for quantized_u8_requant_add_core: directed rounding and clamp cases,
// upper-limit sweeps and a random load/compute stream checked by an in-bench
// requantizer model. Depends on qra_pkg and the core RTL.
module tb_quantized_u8_requant_add_core;
  import qra_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int ONE  = 1 << FRAC;

  typedef struct {
    logic               kind;
    logic [CH_W-1:0]    channel;
    logic [SEL_W-1:0]   sel;
    coef_t              coef;
    logic [BYTE_W-1:0]  a;
    logic [BYTE_W-1:0]  b;
  } txn_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = KIND_LOAD;
  logic [CH_W-1:0]    in_channel = '0;
  logic [SEL_W-1:0]   in_coef_select = '0;
  coef_t              in_coef_value = '0;
  logic [BYTE_W-1:0]  in_a_value = '0;
  logic [BYTE_W-1:0]  in_b_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BYTE_W-1:0]  out_value;
  logic               cfg_wr_en = 1'b0;
  logic [BYTE_W-1:0]  cfg_wr_data = '0;

  coef_set_t          coef_tab [CHANNEL_SLOTS_DEF];
  bit                 is_live [CHANNEL_SLOTS_DEF];
  int                 live_channels [$];
  logic [BYTE_W-1:0]  upper_lim = UPPER_RST;
  logic [BYTE_W-1:0]  expected_bytes [$];
  int                 mismatches = 0;
  bit                 calm = 1'b0;
  int                 rx_hold = 0;

  quantized_u8_requant_add_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_channel     (in_channel),
    .in_coef_select (in_coef_select),
    .in_coef_value  (in_coef_value),
    .in_a_value     (in_a_value),
    .in_b_value     (in_b_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // exact ((a*as+ash)+(b*bs+bsh))*cs+csh, round half to even, clamp 0..lim
  function automatic logic [BYTE_W-1:0] requant_predict(input logic [BYTE_W-1:0] a,
      input logic [BYTE_W-1:0] b, input coef_set_t k, input logic [BYTE_W-1:0] lim);
    logic signed [127:0] av, bv, as_w, ash_w, bs_w, bsh_w, cs_w, csh_w, s, t;
    logic [127:0]        whole;
    logic [2*FRAC-1:0]   frac;
    logic [2*FRAC-1:0]   half;
    av = {120'd0, a};
    bv = {120'd0, b};
    as_w = k.a_scale;
    ash_w = k.a_shift;
    bs_w = k.b_scale;
    bsh_w = k.b_shift;
    cs_w = k.c_scale;
    csh_w = k.c_shift;
    s = av * as_w + ash_w + bv * bs_w + bsh_w;
    t = s * cs_w + (csh_w <<< FRAC);
    if (t < 0) return '0;
    whole = t >> (2 * FRAC);
    frac = t[2*FRAC-1:0];
    half = {1'b1, {(2*FRAC-1){1'b0}}};
    if (frac > half || (frac == half && whole[0])) whole = whole + 1;
    if (whole > lim) return lim;
    return whole[BYTE_W-1:0];
  endfunction

  function automatic coef_t pick_coef(input coef_sel_t sel, input bit coarse);
    coef_t v;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      v = $urandom;
    end else if (mode == 1) begin
      case ($urandom_range(0, 3))
        0: v = {1'b0, {31{1'b1}}};
        1: v = {1'b1, 31'd0};
        2: v = '0;
        default: v = '1;
      endcase
    end else begin
      case (sel)
        SEL_A_SCALE, SEL_B_SCALE: v = $urandom_range(0, 2 * ONE);
        SEL_C_SCALE: v = $urandom_range(0, 3 * ONE / 2);
        SEL_C_SHIFT: v = $urandom_range(0, 256 * ONE) - 128 * ONE;
        default: v = $urandom_range(0, 128 * ONE) - 64 * ONE;
      endcase
      if ((sel == SEL_A_SCALE || sel == SEL_B_SCALE || sel == SEL_C_SCALE) &&
          $urandom_range(0, 5) == 0) v = -v;
    end
    // half-integer coefficients make exact ties common
    if (coarse) v[14:0] = '0;
    return v;
  endfunction

  task automatic send_item(input txn_t t);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= t.kind;
    in_channel <= t.channel;
    in_coef_select <= t.sel;
    in_coef_value <= t.coef;
    in_a_value <= t.a;
    in_b_value <= t.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (t.kind == KIND_LOAD) begin
      case (t.sel)
        SEL_A_SCALE: coef_tab[t.channel].a_scale = t.coef;
        SEL_A_SHIFT: coef_tab[t.channel].a_shift = t.coef;
        SEL_B_SCALE: coef_tab[t.channel].b_scale = t.coef;
        SEL_B_SHIFT: coef_tab[t.channel].b_shift = t.coef;
        SEL_C_SCALE: coef_tab[t.channel].c_scale = t.coef;
        SEL_C_SHIFT: coef_tab[t.channel].c_shift = t.coef;
        default: ;
      endcase
    end else begin
      expected_bytes.push_back(requant_predict(t.a, t.b, coef_tab[t.channel], upper_lim));
    end
  endtask

  task automatic load_coef(input int ch, input logic [SEL_W-1:0] sel, input coef_t v);
    txn_t t;
    t.kind = KIND_LOAD;
    t.channel = CH_W'(ch);
    t.sel = sel;
    t.coef = v;
    t.a = BYTE_W'($urandom_range(0, 255));
    t.b = BYTE_W'($urandom_range(0, 255));
    send_item(t);
  endtask

  task automatic compute_pair(input int ch, input int a, input int b);
    txn_t t;
    t.kind = KIND_COMPUTE;
    t.channel = CH_W'(ch);
    t.sel = SEL_W'($urandom_range(0, 7));
    t.coef = $urandom;
    t.a = BYTE_W'(a);
    t.b = BYTE_W'(b);
    send_item(t);
  endtask

  task automatic load_set(input int ch, input coef_set_t k);
    load_coef(ch, SEL_A_SCALE, k.a_scale);
    load_coef(ch, SEL_A_SHIFT, k.a_shift);
    load_coef(ch, SEL_B_SCALE, k.b_scale);
    load_coef(ch, SEL_B_SHIFT, k.b_shift);
    load_coef(ch, SEL_C_SCALE, k.c_scale);
    load_coef(ch, SEL_C_SHIFT, k.c_shift);
    if (!is_live[ch]) begin
      is_live[ch] = 1'b1;
      live_channels.push_back(ch);
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_upper(input logic [BYTE_W-1:0] v);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    upper_lim = v;
  endtask

  task automatic random_traffic(input int n);
    int        done_count;
    int        r;
    coef_set_t k;
    bit        coarse;
    coef_sel_t s;
    done_count = 0;
    while (done_count < n) begin
      r = $urandom_range(0, 99);
      if (live_channels.size() == 0 || r < 8) begin
        coarse = ($urandom_range(0, 3) == 0);
        k.a_scale = pick_coef(SEL_A_SCALE, coarse);
        k.a_shift = pick_coef(SEL_A_SHIFT, coarse);
        k.b_scale = pick_coef(SEL_B_SCALE, coarse);
        k.b_shift = pick_coef(SEL_B_SHIFT, coarse);
        k.c_scale = pick_coef(SEL_C_SCALE, coarse);
        k.c_shift = pick_coef(SEL_C_SHIFT, coarse);
        load_set($urandom_range(0, CHANNEL_SLOTS_DEF - 1), k);
        done_count += NUM_COEF;
      end else if (r < 12) begin
        s = coef_sel_t'($urandom_range(0, NUM_COEF - 1));
        load_coef(live_channels[$urandom_range(0, live_channels.size() - 1)], s,
                  pick_coef(s, $urandom_range(0, 1) == 1));
        done_count++;
      end else if (r < 15) begin
        // unused selector codes: ignored by the core
        load_coef($urandom_range(0, CHANNEL_SLOTS_DEF - 1),
                  SEL_W'($urandom_range(NUM_COEF, 7)), $urandom);
      end else begin
        compute_pair(live_channels[$urandom_range(0, live_channels.size() - 1)],
                     $urandom_range(0, 255), $urandom_range(0, 255));
        done_count++;
      end
    end
  endtask

  task automatic check_rounding_and_clamps();
    // channel 0: (a + b) / 2
    load_set(0, '{a_scale: ONE, a_shift: 0, b_scale: ONE, b_shift: 0,
                  c_scale: ONE / 2, c_shift: 0});
    compute_pair(0, 0, 0);
    compute_pair(0, 255, 255);
    compute_pair(0, 1, 0);
    compute_pair(0, 3, 0);
    compute_pair(0, 255, 0);
    // channel 1023: extreme coefficients, totals far out of range both ways
    load_set(1023, '{a_scale: {1'b0, {31{1'b1}}}, a_shift: {1'b1, 31'd0},
                     b_scale: {1'b1, 31'd0}, b_shift: {1'b0, {31{1'b1}}},
                     c_scale: {1'b0, {31{1'b1}}}, c_shift: {1'b1, 31'd0}});
    compute_pair(1023, 255, 0);
    compute_pair(1023, 0, 255);
    compute_pair(1023, 0, 0);
    // negative output scale: 300 - (a + b)
    load_coef(0, SEL_C_SCALE, -ONE);
    load_coef(0, SEL_C_SHIFT, 300 * ONE);
    compute_pair(0, 0, 0);
    compute_pair(0, 255, 255);
    compute_pair(0, 100, 100);
    load_coef(0, SEL_W'(NUM_COEF), $urandom);
    load_coef(0, SEL_W'(NUM_COEF + 1), $urandom);
    compute_pair(0, 100, 100);
    quiesce();
  endtask

  task automatic check_limit_settings();
    set_upper(8'd0);
    random_traffic(200);
    set_upper(8'd1);
    random_traffic(200);
    set_upper(BYTE_W'($urandom_range(2, 254)));
    random_traffic(400);
  endtask

  task automatic check_mixed_stream();
    set_upper(8'd255);
    random_traffic(900);
    calm = 1'b1;
    random_traffic(300);
  endtask

  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      rx_hold = $urandom_range(0, 17);
    end else begin
      out_ready <= 1'b1;
      rx_hold = $urandom_range(1, 40);
    end
  end

  always @(posedge clk) begin : check_results
    logic [BYTE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("out_value: expected none, got %0d", out_value);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_value !== want) begin
          $error("out_value: expected %0d, got %0d", want, out_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_rounding_and_clamps();
    check_limit_settings();
    check_mixed_stream();
    quiesce();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
